// File: rtl/tdq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tdq_pkg;

    localparam int MAX_TIMERS   = 16;
    localparam int RESULT_LIMIT = 16;

    localparam int MODE_W = 2;
    localparam int TIME_W = 48;
    localparam int ID_W   = 4;
    localparam int STEP_W = 32;
    localparam int KIND_W = 3;

    localparam int SLOT_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int CNT_W  = $clog2(MAX_TIMERS + 1);
    localparam int RES_W  = $clog2(RESULT_LIMIT + 1);

    localparam logic [MODE_W-1:0] MODE_SUBMIT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CANCEL  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_ADVANCE = 2'd3;

    localparam logic [KIND_W-1:0] KIND_SUBMIT_ACK = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CANCEL_ACK = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FIRED      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR_ACK  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NONE_FIRED = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PUSH
    } state_t;

endpackage

`default_nettype wire

// File: rtl/tdq_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tdq_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [tdq_pkg::MODE_W-1:0]  mode;
    logic [tdq_pkg::TIME_W-1:0]  deadline;
    logic [tdq_pkg::ID_W-1:0]    timer_id;
    logic [tdq_pkg::STEP_W-1:0]  step;

    modport source (output valid, output mode, output deadline, output timer_id,
                    output step, input ready);
    modport sink   (input valid, input mode, input deadline, input timer_id,
                    input step, output ready);
endinterface

interface tdq_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [tdq_pkg::KIND_W-1:0]  kind;
    logic [tdq_pkg::ID_W-1:0]    out_id;
    logic                        success;
    logic                        last;

    modport source (output valid, output kind, output out_id, output success,
                    output last, input ready);
    modport sink   (input valid, input kind, input out_id, input success,
                    input last, output ready);
endinterface

`default_nettype wire

// File: rtl/timer_deadline_queue.sv
// Cancel and clear each give one result.
// Submit and advance run one pass of the shared deadline comparator per fired
// timer plus a final pass.
// One request at a time; the next is taken once the last result is in the output register.
// Reset (async, active low) clears time, armed bits, free stack count and fresh id.
`timescale 1ns / 1ps
`default_nettype none

module timer_deadline_queue (
    input  wire logic  clk,
    input  wire logic  rst_n,
    tdq_cmd_if.sink    cmd,
    tdq_rsp_if.source  rsp
);

    localparam int SLOT_W = tdq_pkg::SLOT_W;
    localparam int TIME_W = tdq_pkg::TIME_W;
    localparam int CNT_W  = tdq_pkg::CNT_W;
    localparam int RES_W  = tdq_pkg::RES_W;
    localparam int KIND_W = tdq_pkg::KIND_W;
    localparam int ID_W   = tdq_pkg::ID_W;
    localparam int NT     = tdq_pkg::MAX_TIMERS;

    tdq_pkg::state_t state_reg, state_next;

    logic [TIME_W-1:0]  now_reg, now_next;
    logic [NT-1:0]      armed_reg, armed_next;
    logic [CNT_W-1:0]   free_count_reg, free_count_next;
    logic [CNT_W-1:0]   fresh_reg, fresh_next;

    logic [TIME_W-1:0]  dl_mem [NT];
    logic [SLOT_W-1:0]  stack_mem [NT];

    logic               dl_we;
    logic [SLOT_W-1:0]  dl_waddr;
    logic               stk_we;
    logic [SLOT_W-1:0]  stk_waddr;
    logic [SLOT_W-1:0]  stk_wdata;
    logic [SLOT_W-1:0]  stk_raddr;

    logic [SLOT_W-1:0]  scan_idx_reg, scan_idx_next;
    logic               found_reg, found_next;
    logic [SLOT_W-1:0]  best_id_reg, best_id_next;
    logic [TIME_W-1:0]  best_dl_reg, best_dl_next;
    logic [SLOT_W-1:0]  fire_id_reg, fire_id_next;
    logic [RES_W-1:0]   res_cnt_reg, res_cnt_next;
    logic               have_pend_reg, have_pend_next;
    logic               push_final_reg, push_final_next;

    logic [KIND_W-1:0]  pend_kind_reg, pend_kind_next;
    logic [ID_W-1:0]    pend_id_reg, pend_id_next;
    logic               pend_ok_reg, pend_ok_next;

    logic               out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]  out_kind_reg, out_kind_next;
    logic [ID_W-1:0]    out_id_reg, out_id_next;
    logic               out_ok_reg, out_ok_next;
    logic               out_last_reg, out_last_next;

    logic               cmd_fire;
    logic               out_free;
    logic [TIME_W-1:0]  rd_dl_reg;
    logic               cand;
    logic               found_scan;
    logic [SLOT_W-1:0]  best_id_scan;
    logic               scan_last;
    logic               fire_ok;
    logic [TIME_W:0]    time_sum;
    logic [SLOT_W-1:0]  cancel_slot;
    logic [SLOT_W-1:0]  pop_id_reg;
    logic [SLOT_W-1:0]  release_id;
    logic               release_en;

    assign cmd.ready   = (state_reg == tdq_pkg::ST_IDLE);
    assign cmd_fire    = cmd.valid && cmd.ready;
    assign out_free    = !out_valid_reg || rsp.ready;

    assign rsp.valid   = out_valid_reg;
    assign rsp.kind    = out_kind_reg;
    assign rsp.out_id  = out_id_reg;
    assign rsp.success = out_ok_reg;
    assign rsp.last    = out_last_reg;

    // one step of the shared deadline compare; ties keep the lower id
    assign cand         = armed_reg[scan_idx_reg] && (rd_dl_reg <= now_reg) &&
                          (!found_reg || (rd_dl_reg < best_dl_reg));
    assign found_scan   = found_reg || cand;
    assign best_id_scan = cand ? scan_idx_reg : best_id_reg;
    assign scan_last    = (scan_idx_reg == SLOT_W'(NT - 1));
    assign fire_ok      = found_scan && (res_cnt_reg < RES_W'(tdq_pkg::RESULT_LIMIT));

    assign time_sum     = {1'b0, now_reg} + (TIME_W + 1)'(cmd.step);
    assign cancel_slot  = SLOT_W'(cmd.timer_id);
    // top of the free stack as it stands after this cycle
    assign stk_raddr    = SLOT_W'(free_count_next - CNT_W'(1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tdq_pkg::ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    if (cmd.mode == tdq_pkg::MODE_SUBMIT || cmd.mode == tdq_pkg::MODE_ADVANCE)
                        state_next = tdq_pkg::ST_SCAN;
                    else
                        state_next = tdq_pkg::ST_PUSH;
                end
            end
            tdq_pkg::ST_SCAN:
            begin
                if (scan_last)
                begin
                    if (fire_ok && !have_pend_reg)
                        state_next = tdq_pkg::ST_SCAN;
                    else
                        state_next = tdq_pkg::ST_PUSH;
                end
            end
            tdq_pkg::ST_PUSH:
            begin
                if (out_free)
                    state_next = push_final_reg ? tdq_pkg::ST_IDLE : tdq_pkg::ST_SCAN;
            end
            default:
            begin
                state_next = tdq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        now_next        = now_reg;
        armed_next      = armed_reg;
        free_count_next = free_count_reg;
        fresh_next      = fresh_reg;
        dl_we           = 1'b0;
        dl_waddr        = '0;
        release_en      = 1'b0;
        release_id      = '0;
        scan_idx_next   = scan_idx_reg;
        found_next      = found_reg;
        best_id_next    = best_id_reg;
        best_dl_next    = best_dl_reg;
        fire_id_next    = fire_id_reg;
        res_cnt_next    = res_cnt_reg;
        have_pend_next  = have_pend_reg;
        push_final_next = push_final_reg;
        pend_kind_next  = pend_kind_reg;
        pend_id_next    = pend_id_reg;
        pend_ok_next    = pend_ok_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_kind_next   = out_kind_reg;
        out_id_next     = out_id_reg;
        out_ok_next     = out_ok_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            tdq_pkg::ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    scan_idx_next = '0;
                    found_next    = 1'b0;
                    unique case (cmd.mode)
                        tdq_pkg::MODE_SUBMIT:
                        begin
                            pend_kind_next = tdq_pkg::KIND_SUBMIT_ACK;
                            pend_id_next   = '0;
                            pend_ok_next   = 1'b0;
                            if (free_count_reg != '0)
                            begin
                                free_count_next = free_count_reg - CNT_W'(1);
                                dl_waddr        = pop_id_reg;
                                dl_we           = 1'b1;
                            end
                            else if (fresh_reg < CNT_W'(NT))
                            begin
                                fresh_next = fresh_reg + CNT_W'(1);
                                dl_waddr   = SLOT_W'(fresh_reg);
                                dl_we      = 1'b1;
                            end
                            if (dl_we)
                            begin
                                armed_next[dl_waddr] = 1'b1;
                                pend_id_next         = ID_W'(dl_waddr);
                                pend_ok_next         = 1'b1;
                            end
                            have_pend_next = 1'b1;
                            res_cnt_next   = RES_W'(1);
                        end
                        tdq_pkg::MODE_CANCEL:
                        begin
                            pend_kind_next  = tdq_pkg::KIND_CANCEL_ACK;
                            pend_id_next    = cmd.timer_id;
                            pend_ok_next    = 1'b0;
                            push_final_next = 1'b1;
                            have_pend_next  = 1'b1;
                            if ((int'(cmd.timer_id) < NT) && armed_reg[cancel_slot])
                            begin
                                armed_next[cancel_slot] = 1'b0;
                                release_en              = 1'b1;
                                release_id              = cancel_slot;
                                pend_ok_next            = 1'b1;
                            end
                        end
                        tdq_pkg::MODE_CLEAR:
                        begin
                            armed_next      = '0;
                            free_count_next = '0;
                            fresh_next      = '0;
                            pend_kind_next  = tdq_pkg::KIND_CLEAR_ACK;
                            pend_id_next    = '0;
                            pend_ok_next    = 1'b0;
                            push_final_next = 1'b1;
                            have_pend_next  = 1'b1;
                        end
                        tdq_pkg::MODE_ADVANCE:
                        begin
                            now_next       = time_sum[TIME_W] ? '1 : time_sum[TIME_W-1:0];
                            have_pend_next = 1'b0;
                            res_cnt_next   = '0;
                        end
                        default:
                        begin
                            have_pend_next = have_pend_reg;
                        end
                    endcase
                end
            end
            tdq_pkg::ST_SCAN:
            begin
                if (!scan_last)
                begin
                    scan_idx_next = scan_idx_reg + SLOT_W'(1);
                    found_next    = found_scan;
                    best_id_next  = best_id_scan;
                    if (cand)
                        best_dl_next = rd_dl_reg;
                end
                else if (fire_ok)
                begin
                    armed_next[best_id_scan] = 1'b0;
                    release_en      = 1'b1;
                    release_id      = best_id_scan;
                    fire_id_next    = best_id_scan;
                    push_final_next = 1'b0;
                    scan_idx_next   = '0;
                    found_next      = 1'b0;
                    if (!have_pend_reg)
                    begin
                        // first fire of an advance: nothing older waits to go out
                        pend_kind_next = tdq_pkg::KIND_FIRED;
                        pend_id_next   = ID_W'(best_id_scan);
                        pend_ok_next   = 1'b0;
                        have_pend_next = 1'b1;
                        res_cnt_next   = res_cnt_reg + RES_W'(1);
                    end
                end
                else
                begin
                    push_final_next = 1'b1;
                    if (!have_pend_reg)
                    begin
                        pend_kind_next = tdq_pkg::KIND_NONE_FIRED;
                        pend_id_next   = '0;
                        pend_ok_next   = 1'b0;
                        have_pend_next = 1'b1;
                    end
                end
            end
            tdq_pkg::ST_PUSH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = pend_kind_reg;
                    out_id_next    = pend_id_reg;
                    out_ok_next    = pend_ok_reg;
                    out_last_next  = push_final_reg;
                    if (!push_final_reg)
                    begin
                        pend_kind_next = tdq_pkg::KIND_FIRED;
                        pend_id_next   = ID_W'(fire_id_reg);
                        pend_ok_next   = 1'b0;
                        res_cnt_next   = res_cnt_reg + RES_W'(1);
                        scan_idx_next  = '0;
                        found_next     = 1'b0;
                    end
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg;
            end
        endcase

        stk_we    = release_en && (free_count_reg < CNT_W'(NT));
        stk_waddr = SLOT_W'(free_count_reg);
        stk_wdata = release_id;
        if (stk_we)
            free_count_next = free_count_reg + CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tdq_pkg::ST_IDLE;
            now_reg        <= '0;
            armed_reg      <= '0;
            free_count_reg <= '0;
            fresh_reg      <= '0;
            scan_idx_reg   <= '0;
            found_reg      <= 1'b0;
            res_cnt_reg    <= '0;
            have_pend_reg  <= 1'b0;
            push_final_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            now_reg        <= now_next;
            armed_reg      <= armed_next;
            free_count_reg <= free_count_next;
            fresh_reg      <= fresh_next;
            scan_idx_reg   <= scan_idx_next;
            found_reg      <= found_next;
            res_cnt_reg    <= res_cnt_next;
            have_pend_reg  <= have_pend_next;
            push_final_reg <= push_final_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_id_reg   <= best_id_next;
        best_dl_reg   <= best_dl_next;
        fire_id_reg   <= fire_id_next;
        pend_kind_reg <= pend_kind_next;
        pend_id_reg   <= pend_id_next;
        pend_ok_reg   <= pend_ok_next;
        out_kind_reg  <= out_kind_next;
        out_id_reg    <= out_id_next;
        out_ok_reg    <= out_ok_next;
        out_last_reg  <= out_last_next;
    end

    // registered reads; a write to the address being read passes straight through
    always_ff @(posedge clk)
    begin
        if (dl_we)
            dl_mem[dl_waddr] <= cmd.deadline;
        if (stk_we)
            stack_mem[stk_waddr] <= stk_wdata;
        if (dl_we && (dl_waddr == scan_idx_next))
            rd_dl_reg <= cmd.deadline;
        else
            rd_dl_reg <= dl_mem[scan_idx_next];
        if (stk_we && (stk_waddr == stk_raddr))
            pop_id_reg <= stk_wdata;
        else
            pop_id_reg <= stack_mem[stk_raddr];
    end

endmodule

`default_nettype wire

// File: test/tdq_checker.sv
`timescale 1ns / 1ps

module tdq_checker (
    input  logic clk,
    input  logic rst_n,
    tdq_cmd_if   cmd,
    tdq_rsp_if   rsp,
    output int   fail_count,
    output int   pending
);

    localparam int KIND_W       = tdq_pkg::KIND_W;
    localparam int ID_W         = tdq_pkg::ID_W;
    localparam int TIME_W       = tdq_pkg::TIME_W;
    localparam int MODE_W       = tdq_pkg::MODE_W;
    localparam int STEP_W       = tdq_pkg::STEP_W;
    localparam int MAX_TIMERS   = tdq_pkg::MAX_TIMERS;
    localparam int RESULT_LIMIT = tdq_pkg::RESULT_LIMIT;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic              success;
        logic              last;
    } timer_rsp_t;

    // shadow copy of the timer store
    logic [TIME_W-1:0] shadow_now;
    logic [TIME_W-1:0] slot_dl  [MAX_TIMERS];
    logic              slot_on  [MAX_TIMERS];
    logic [ID_W-1:0]   free_ids [MAX_TIMERS];
    int                free_n;
    int                fresh_n;

    timer_rsp_t rsp_owed [$];
    timer_rsp_t head;
    int         err_n;

    task automatic flag(input string msg);
        $display("tdq_checker: %s", msg);
        err_n++;
    endtask

    function automatic timer_rsp_t rsp_item(input logic [KIND_W-1:0] k,
                                            input logic [ID_W-1:0] id, input logic ok);
        timer_rsp_t r;
        r.kind    = k;
        r.id      = id;
        r.success = ok;
        r.last    = 1'b0;
        return r;
    endfunction

    task automatic free_slot(input int id);
        if (free_n < MAX_TIMERS) begin
            free_ids[free_n] = ID_W'(id);
            free_n++;
        end
    endtask

    task automatic apply_timer_cmd(input logic [MODE_W-1:0] mode,
                                   input logic [TIME_W-1:0] dl,
                                   input logic [ID_W-1:0]   tid,
                                   input logic [STEP_W-1:0] step);
        timer_rsp_t      batch [RESULT_LIMIT];
        int              n;
        int              slot;
        int              pick;
        logic            got;
        logic            scan;
        logic [TIME_W:0] sum;
        n    = 0;
        scan = 1'b0;
        case (mode)
            tdq_pkg::MODE_SUBMIT: begin
                got  = 1'b1;
                slot = 0;
                if (free_n > 0) begin
                    free_n--;
                    slot = free_ids[free_n];
                end else if (fresh_n < MAX_TIMERS) begin
                    slot = fresh_n;
                    fresh_n++;
                end else
                    got = 1'b0;
                if (got) begin
                    slot_dl[slot] = dl;
                    slot_on[slot] = 1'b1;
                end
                batch[0] = rsp_item(tdq_pkg::KIND_SUBMIT_ACK, got ? ID_W'(slot) : '0, got);
                n    = 1;
                scan = 1'b1;
            end
            tdq_pkg::MODE_CANCEL: begin
                got = slot_on[tid];
                if (got) begin
                    slot_on[tid] = 1'b0;
                    free_slot(tid);
                end
                batch[0] = rsp_item(tdq_pkg::KIND_CANCEL_ACK, tid, got);
                n = 1;
            end
            tdq_pkg::MODE_CLEAR: begin
                for (int i = 0; i < MAX_TIMERS; i++)
                    slot_on[i] = 1'b0;
                free_n   = 0;
                fresh_n  = 0;
                batch[0] = rsp_item(tdq_pkg::KIND_CLEAR_ACK, '0, 1'b0);
                n = 1;
            end
            default: begin
                sum        = {1'b0, shadow_now} + step;
                shadow_now = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
                scan       = 1'b1;
            end
        endcase
        // earliest deadline first; strict compare keeps the lowest id on ties
        while (scan && n < RESULT_LIMIT) begin
            pick = -1;
            for (int i = 0; i < MAX_TIMERS; i++)
                if (slot_on[i] && slot_dl[i] <= shadow_now &&
                    (pick < 0 || slot_dl[i] < slot_dl[pick]))
                    pick = i;
            if (pick < 0)
                scan = 1'b0;
            else begin
                slot_on[pick] = 1'b0;
                free_slot(pick);
                batch[n] = rsp_item(tdq_pkg::KIND_FIRED, ID_W'(pick), 1'b0);
                n++;
            end
        end
        if (n == 0) begin
            batch[0] = rsp_item(tdq_pkg::KIND_NONE_FIRED, '0, 1'b0);
            n = 1;
        end
        for (int i = 0; i < n; i++) begin
            batch[i].last = (i == n - 1);
            rsp_owed.push_back(batch[i]);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            shadow_now = '0;
            for (int i = 0; i < MAX_TIMERS; i++) begin
                slot_on[i]  = 1'b0;
                slot_dl[i]  = '0;
                free_ids[i] = '0;
            end
            free_n  = 0;
            fresh_n = 0;
            err_n   = 0;
            rsp_owed.delete();
            pending    <= 0;
            fail_count <= 0;
        end else begin
            if (cmd.valid && cmd.ready)
                apply_timer_cmd(cmd.mode, cmd.deadline, cmd.timer_id, cmd.step);
            if (rsp.valid && rsp.ready) begin
                if (rsp_owed.size() == 0)
                    flag($sformatf("unexpected response kind %0d id %0d", rsp.kind,
                                   rsp.out_id));
                else begin
                    head = rsp_owed[0];
                    rsp_owed.delete(0);
                    if (rsp.kind !== head.kind)
                        flag($sformatf("kind %0d, want %0d", rsp.kind, head.kind));
                    if (rsp.out_id !== head.id)
                        flag($sformatf("out_id %0d, want %0d (kind %0d)", rsp.out_id,
                                       head.id, head.kind));
                    if (rsp.success !== head.success)
                        flag($sformatf("success %0b, want %0b (kind %0d id %0d)",
                                       rsp.success, head.success, head.kind, head.id));
                    if (rsp.last !== head.last)
                        flag($sformatf("last %0b, want %0b (kind %0d id %0d)",
                                       rsp.last, head.last, head.kind, head.id));
                end
            end
            pending    <= rsp_owed.size();
            fail_count <= err_n;
        end
    end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int TIME_W     = tdq_pkg::TIME_W;
    localparam int MODE_W     = tdq_pkg::MODE_W;
    localparam int ID_W       = tdq_pkg::ID_W;
    localparam int STEP_W     = tdq_pkg::STEP_W;
    localparam int MAX_TIMERS = tdq_pkg::MAX_TIMERS;

    localparam int ITEMS       = 480;
    localparam int STALL_LIMIT = 3000;
    localparam int TAIL_CYCLES = 300;
    localparam logic [TIME_W-1:0] TIME_TOP = '1;

    logic clk = 1'b0;
    logic rst_n;

    tdq_cmd_if cmd ();
    tdq_rsp_if rsp ();

    int fail_count;
    int pending;

    timer_deadline_queue u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    tdq_checker u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #1 clk = ~clk;

    // stimulus-side view of time, used only to aim deadlines
    logic [TIME_W-1:0] now_est;
    logic [TIME_W-1:0] last_dl;
    int                sent;
    int                burst_left;
    logic              steady = 1'b0;

    // receiver: a randomly chosen stall style, or always ready while steady
    int rdy_left;
    int rdy_style;

    initial begin
        rsp.ready = 1'b0;
        rdy_left  = 0;
        rdy_style = 0;
        forever begin
            @(posedge clk);
            if (rdy_left == 0) begin
                rdy_style = $urandom_range(0, 3);
                rdy_left  = $urandom_range(16, 80);
            end
            rdy_left--;
            if (steady)
                rsp.ready <= 1'b1;
            else
                case (rdy_style)
                    0: rsp.ready <= 1'b1;
                    1: rsp.ready <= $urandom_range(0, 1);
                    2: rsp.ready <= ($urandom_range(0, 3) == 0);
                    default: rsp.ready <= ((rdy_left % 7) < 4);
                endcase
        end
    end

    int quiet = 0;

    always @(posedge clk) begin
        if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    task automatic pace();
        int gap;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0 && !steady) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                cmd.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
    endtask

    task automatic issue(input logic [MODE_W-1:0] m, input logic [TIME_W-1:0] d,
                         input logic [ID_W-1:0] id, input logic [STEP_W-1:0] s);
        logic [TIME_W:0] wide;
        cmd.valid    <= 1'b1;
        cmd.mode     <= m;
        cmd.deadline <= d;
        cmd.timer_id <= id;
        cmd.step     <= s;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        if (m == tdq_pkg::MODE_ADVANCE) begin
            wide    = {1'b0, now_est} + s;
            now_est = wide[TIME_W] ? TIME_TOP : wide[TIME_W-1:0];
        end
        if (m == tdq_pkg::MODE_SUBMIT)
            last_dl = d;
        sent++;
        pace();
    endtask

    // hold off new requests until every owed response is back
    task automatic drain();
        cmd.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [TIME_W-1:0] pick_deadline(input logic close);
        if (close)
            return ($urandom_range(0, 3) == 0) ? last_dl : now_est + $urandom_range(0, 60);
        case ($urandom_range(0, 5))
            0: return (now_est > 20) ? now_est - $urandom_range(0, 20) : '0;
            1: return last_dl;
            2: return TIME_W'({$urandom, $urandom});
            3: return now_est + $urandom_range(0, 1 << 20);
            default: return now_est + $urandom_range(0, 300);
        endcase
    endfunction

    function automatic logic [STEP_W-1:0] pick_step();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return $urandom;
            2: return $urandom_range(0, 2000);
            default: return $urandom_range(0, 150);
        endcase
    endfunction

    task automatic random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            issue(tdq_pkg::MODE_SUBMIT, pick_deadline(1'b0), ID_W'($urandom), $urandom);
        else if (r < 65)
            issue(tdq_pkg::MODE_CANCEL, TIME_W'({$urandom, $urandom}), ID_W'($urandom),
                  $urandom);
        else if (r < 68)
            issue(tdq_pkg::MODE_CLEAR, TIME_W'({$urandom, $urandom}), ID_W'($urandom),
                  $urandom);
        else
            issue(tdq_pkg::MODE_ADVANCE, TIME_W'({$urandom, $urandom}), ID_W'($urandom),
                  pick_step());
    endtask

    initial begin
        int j;
        int n;
        int pick;
        int next_drain;
        rst_n        = 1'b0;
        cmd.valid    = 1'b0;
        cmd.mode     = tdq_pkg::MODE_SUBMIT;
        cmd.deadline = '0;
        cmd.timer_id = '0;
        cmd.step     = '0;
        now_est      = '0;
        last_dl      = '0;
        sent         = 0;
        burst_left   = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(tdq_pkg::MODE_ADVANCE, '0, '0, '0);
        issue(tdq_pkg::MODE_SUBMIT, 48'd0, '0, '0);     // already due: ack then fire
        issue(tdq_pkg::MODE_SUBMIT, 48'd100, '0, '0);
        issue(tdq_pkg::MODE_SUBMIT, 48'd100, '0, '0);
        issue(tdq_pkg::MODE_SUBMIT, 48'd50, '0, '0);
        issue(tdq_pkg::MODE_CANCEL, '0, 4'd1, '0);
        issue(tdq_pkg::MODE_ADVANCE, '0, '0, 32'd100);
        // fill the store from freed and fresh ids; deadlines tie in groups
        for (j = 0; j < MAX_TIMERS; j++)
            issue(tdq_pkg::MODE_SUBMIT, TIME_W'(400 - (j % 4) * 10), '1, '1);
        issue(tdq_pkg::MODE_SUBMIT, 48'd150, '0, '0);   // no id left
        issue(tdq_pkg::MODE_CANCEL, '1, 4'd15, '1);
        issue(tdq_pkg::MODE_ADVANCE, '1, '1, 32'hFFFF_FFFF);
        issue(tdq_pkg::MODE_CANCEL, '0, 4'd15, '0);
        drain();

        next_drain = sent + $urandom_range(40, 90);
        while (sent < ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                // a group of timers close together, then time walked over them and some cancels
                n = $urandom_range(2, MAX_TIMERS + 1);
                for (j = 0; j < n; j++)
                    issue(tdq_pkg::MODE_SUBMIT, pick_deadline(1'b1), ID_W'($urandom),
                          $urandom);
                n = $urandom_range(1, 5);
                for (j = 0; j < n; j++)
                    if ($urandom_range(0, 3) == 0)
                        issue(tdq_pkg::MODE_CANCEL, TIME_W'({$urandom, $urandom}),
                              ID_W'($urandom_range(0, MAX_TIMERS - 1)), $urandom);
                    else
                        issue(tdq_pkg::MODE_ADVANCE, TIME_W'({$urandom, $urandom}),
                              ID_W'($urandom), $urandom_range(0, 60));
            end else
                random_item();
            if (sent >= next_drain) begin
                drain();
                next_drain = sent + $urandom_range(40, 90);
            end
        end

        // deadlines at the top of the time range, a big step, then one already past
        steady <= 1'b1;
        drain();
        issue(tdq_pkg::MODE_CLEAR, '0, '0, '0);
        issue(tdq_pkg::MODE_SUBMIT, TIME_TOP, '0, '0);
        issue(tdq_pkg::MODE_SUBMIT, TIME_TOP - 1, '0, '0);
        issue(tdq_pkg::MODE_SUBMIT, TIME_TOP, '0, '0);
        issue(tdq_pkg::MODE_SUBMIT, now_est + 5, '0, '0);
        issue(tdq_pkg::MODE_ADVANCE, '0, '0, 32'hFFFF_FFFF);
        issue(tdq_pkg::MODE_ADVANCE, '0, '0, 32'd1);
        issue(tdq_pkg::MODE_SUBMIT, TIME_TOP, '0, '0);
        issue(tdq_pkg::MODE_SUBMIT, '0, '0, '0);
        steady <= 1'b0;
        issue(tdq_pkg::MODE_CANCEL, '0, 4'd15, '0);

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

// File: filelist.f
rtl/tdq_pkg.sv
rtl/tdq_if.sv
rtl/timer_deadline_queue.sv
test/tdq_checker.sv
test/tb.sv
